// ===== rtl/wbc_pkg.sv =====
// Shared constants, codes and types for the weighting biquad cascade.
package wbc_pkg;

    // Default build parameters
    localparam int DEF_SECTIONS       = 5;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 28;

    // Fixed datapath widths
    localparam int DATA_W    = 32;      // section signal and coefficient width
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + 3;  // headroom for five exact products
    localparam int MASK_W    = 5;       // section enable mask width
    localparam int CADDR_W   = 5;       // coef_address port width
    localparam int CFG_W     = MASK_W;  // widest configuration register
    localparam int CFG_IDX_W = 1;

    // Storage layout per section
    localparam int COEFS_PER_SEC  = 5;
    localparam int DELAYS_PER_SEC = 4;

    // Input opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_COEF   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_EN = 1'b1;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic mul_en;    // load product register
        logic acc_en;    // update accumulator
        logic acc_init;  // start a new sum with the product
        logic acc_sub;   // subtract the product (feedback terms)
    } mac_ctrl_t;

endpackage

// ===== rtl/wbc_coef_mem.sv =====
// Coefficient memory: one write port, one registered read port.
module wbc_coef_mem
    import wbc_pkg::*;
#(
    parameter int SECTIONS = DEF_SECTIONS
)
(
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [$clog2(SECTIONS*COEFS_PER_SEC)-1:0]   wr_addr,
    input  logic signed [DATA_W-1:0]                    wr_data,
    input  logic [$clog2(SECTIONS*COEFS_PER_SEC)-1:0]   rd_addr,
    output logic signed [DATA_W-1:0]                    rd_data
);

    localparam int DEPTH = SECTIONS * COEFS_PER_SEC;

    logic signed [DATA_W-1:0] store_mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wbc_delay_mem.sv =====
// Delay-line memory with per-entry valid bits; invalid entries read as zero.
module wbc_delay_mem
    import wbc_pkg::*;
#(
    parameter int SECTIONS = DEF_SECTIONS
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         clear,
    input  logic                                         wr_en,
    input  logic [$clog2(SECTIONS*DELAYS_PER_SEC)-1:0]   wr_addr,
    input  logic signed [DATA_W-1:0]                     wr_data,
    input  logic [$clog2(SECTIONS*DELAYS_PER_SEC)-1:0]   rd_addr,
    output logic signed [DATA_W-1:0]                     rd_data
);

    localparam int DEPTH = SECTIONS * DELAYS_PER_SEC;

    logic signed [DATA_W-1:0] store_mem [DEPTH];
    logic [DEPTH-1:0]         valid_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    // Data array and registered read, masked by the valid bit
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? store_mem[rd_addr] : '0;
    end

    // Valid bits: cleared by reset or a clear transfer, set on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wbc_mac.sv =====
// Shared multiply-accumulate unit with rounding and 32-bit saturation.
module wbc_mac
    import wbc_pkg::*;
#(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] coef,
    input  logic signed [DATA_W-1:0] opnd,
    output logic signed [DATA_W-1:0] y
);

    localparam int SH_W = ACC_W - COEF_FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [SH_W-1:0]   shifted;
    logic [SH_W-DATA_W:0]     top_bits;

    // Product stage
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * opnd;
        end
    end

    // Accumulate stage
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        if (ctrl.acc_init)
        begin
            acc_next = prod_ext;
        end
        else if (ctrl.acc_sub)
        begin
            acc_next = acc_reg - prod_ext;
        end
        else
        begin
            acc_next = acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round half up, drop fraction bits, saturate to 32 bits
    always_comb
    begin
        rnd      = acc_reg + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
        shifted  = rnd[ACC_W-1:COEF_FRAC_BITS];
        top_bits = shifted[SH_W-1:DATA_W-1];
        if ((&top_bits) || !(|top_bits))
        begin
            y = shifted[DATA_W-1:0];
        end
        else if (shifted[SH_W-1])
        begin
            y = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            y = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

// ===== rtl/weighting_biquad_cascade_core.sv =====
// Weighting filter: cascade of direct-form-I biquad sections on one shared MAC.
//
// Channels: the input channel (in_valid/in_stall) carries opcode, coef_address,
// coef_value, sample_in and block_end; a transfer happens when in_valid is high
// and in_stall is low. Opcode 1 writes a coefficient, opcode 2 clears all delay
// state; neither gives a result. Opcode 0 filters a sample and gives one result
// on the output channel (out_valid/out_stall): sample_out, ok and block_end_out.
// The configuration port (cfg_write, cfg_index, cfg_data) sets enable and the
// section mask; write it only while the block is idle. A sample keeps the input
// stalled until it is done: the sequencer scans the sections in turn, and each
// enabled section runs eight steps of the single read port / multiplier
// schedule: five coefficient and delay reads, a product stage, an accumulate
// stage and a rounding and write-back step. The finish state registers the
// result once the output register is free, and the next item goes in after
// that. With enable low the sample goes straight to the finish state, and its
// result has ok low and a zero sample_out.
// Reset clears the control registers, mask and delay valid bits (delays read as
// zero, no clearing pass); the coefficient memory holds nothing until written.
// A stalled result stays in the output register; a new item is still taken
// and processed, and its result waits until the output register frees up.
module weighting_biquad_cascade_core
    import wbc_pkg::*;
#(
    parameter int SECTIONS       = DEF_SECTIONS,
    parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [CADDR_W-1:0]            coef_address,
    input  logic signed [DATA_W-1:0]      coef_value,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          block_end,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          ok,
    output logic                          block_end_out
);

    localparam int NCOEF  = SECTIONS * COEFS_PER_SEC;
    localparam int NDELAY = SECTIONS * DELAYS_PER_SEC;
    localparam int CAW    = $clog2(NCOEF);
    localparam int DAW    = $clog2(NDELAY);
    localparam int SW     = $clog2(SECTIONS + 1);
    localparam int XW     = SAMPLE_BITS + 9;   // scaled input with a spare bit
    localparam int RW     = DATA_W + 2;        // output rounding width

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [SW-1:0]            sec_reg, sec_next;
    logic [2:0]               step_reg, step_next;
    logic signed [DATA_W-1:0] v_reg, v_next;
    logic signed [DATA_W-1:0] hold_reg;
    logic                     bend_reg;
    logic                     okflag_reg, okflag_next;
    logic                     enable_reg;
    logic [MASK_W-1:0]        sect_en_reg;
    logic                     out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                     out_ok_reg;
    logic                     out_bend_reg;

    logic                     in_xfer;
    logic                     out_free;
    logic                     sec_done;
    logic                     sec_active;
    logic [3:0]               sec_ext;
    logic [7:0]               mask_ext;
    logic [5:0]               coef_base;
    logic [5:0]               dly_base;
    logic [5:0]               caddr_ext;
    logic [2:0]               coef_k;
    logic [5:0]               coef_rd_full;
    logic [5:0]               dly_rd_full;
    logic [5:0]               dly_wr_full;
    logic [1:0]               dly_wr_off;

    logic                     coef_we;
    logic [CAW-1:0]           coef_waddr;
    logic [CAW-1:0]           coef_raddr;
    logic signed [DATA_W-1:0] coef_rd;
    logic                     dly_clear;
    logic                     dly_we;
    logic [DAW-1:0]           dly_waddr;
    logic signed [DATA_W-1:0] dly_wdata;
    logic [DAW-1:0]           dly_raddr;
    logic signed [DATA_W-1:0] dly_rd;

    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] mac_opnd;
    logic signed [DATA_W-1:0] mac_y;

    logic signed [XW-1:0]     x_scaled;
    logic [XW-DATA_W:0]       x_top;
    logic signed [DATA_W-1:0] x_sat;
    logic signed [RW-1:0]     r_full;
    logic [RW-SAMPLE_BITS:0]  r_top;
    logic signed [SAMPLE_BITS-1:0] r_sat;

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Section bookkeeping
    assign sec_ext    = 4'(sec_reg);
    assign mask_ext   = 8'(sect_en_reg);
    assign sec_done   = (sec_reg == SW'(SECTIONS));
    assign sec_active = mask_ext[sec_ext[2:0]];
    assign coef_base  = 6'(sec_ext) * 6'(COEFS_PER_SEC);
    assign dly_base   = {sec_ext, 2'b00};

    // Coefficient writes from the input channel
    assign caddr_ext  = 6'(coef_address);
    assign coef_we    = in_xfer && (opcode == OP_COEF) && (caddr_ext < 6'(NCOEF));
    assign coef_waddr = caddr_ext[CAW-1:0];

    // Read addresses: coefficient k at step k, delay k-1 at step k
    assign coef_k       = (step_reg < 3'(COEFS_PER_SEC)) ? step_reg : 3'd0;
    assign coef_rd_full = coef_base + 6'(coef_k);
    assign coef_raddr   = coef_rd_full[CAW-1:0];
    assign dly_rd_full  = dly_base + ((step_reg >= 3'd1 && step_reg <= 3'd4)
                                      ? 6'(step_reg - 3'd1) : 6'd0);
    assign dly_raddr    = dly_rd_full[DAW-1:0];

    // Delay write-back schedule: x1 <- x, x2 <- x1, y2 <- y1, y1 <- y
    always_comb
    begin
        dly_we     = 1'b0;
        dly_wr_off = 2'd0;
        dly_wdata  = v_reg;
        if (state_reg == ST_RUN)
        begin
            case (step_reg)
                3'd2:
                begin
                    dly_we     = 1'b1;
                    dly_wr_off = 2'd0;
                    dly_wdata  = v_reg;
                end
                3'd3:
                begin
                    dly_we     = 1'b1;
                    dly_wr_off = 2'd1;
                    dly_wdata  = hold_reg;
                end
                3'd5:
                begin
                    dly_we     = 1'b1;
                    dly_wr_off = 2'd3;
                    dly_wdata  = hold_reg;
                end
                3'd7:
                begin
                    dly_we     = 1'b1;
                    dly_wr_off = 2'd2;
                    dly_wdata  = mac_y;
                end
                default:
                begin
                    dly_we = 1'b0;
                end
            endcase
        end
    end

    assign dly_wr_full = dly_base + 6'(dly_wr_off);
    assign dly_waddr   = dly_wr_full[DAW-1:0];
    assign dly_clear   = in_xfer && (opcode == OP_CLEAR);

    // MAC control: product at steps 1..5, accumulate at steps 2..6
    always_comb
    begin
        mac_ctrl.mul_en   = (state_reg == ST_RUN) && (step_reg >= 3'd1) && (step_reg <= 3'd5);
        mac_ctrl.acc_en   = (state_reg == ST_RUN) && (step_reg >= 3'd2) && (step_reg <= 3'd6);
        mac_ctrl.acc_init = (step_reg == 3'd2);
        mac_ctrl.acc_sub  = (step_reg >= 3'd5);
    end

    assign mac_opnd = (step_reg == 3'd1) ? v_reg : dly_rd;

    // Input scaling by 2^8 with saturation to 32 bits
    always_comb
    begin
        x_scaled = XW'(sample_in) <<< 8;
        x_top    = x_scaled[XW-1:DATA_W-1];
        if ((&x_top) || !(|x_top))
        begin
            x_sat = x_scaled[DATA_W-1:0];
        end
        else if (x_scaled[XW-1])
        begin
            x_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            x_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // Final rounding (v + 128) >> 8 and saturation to the sample width
    always_comb
    begin
        r_full = (RW'(v_reg) + RW'(128)) >>> 8;
        r_top  = r_full[RW-1:SAMPLE_BITS-1];
        if ((&r_top) || !(|r_top))
        begin
            r_sat = r_full[SAMPLE_BITS-1:0];
        end
        else if (r_full[RW-1])
        begin
            r_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        sec_next    = sec_reg;
        step_next   = step_reg;
        v_next      = v_reg;
        okflag_next = okflag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (opcode == OP_SAMPLE))
                begin
                    sec_next  = '0;
                    step_next = 3'd0;
                    v_next    = x_sat;
                    if (enable_reg)
                    begin
                        okflag_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        okflag_next = 1'b0;
                        state_next  = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                step_next = 3'd0;
                if (sec_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (sec_active)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    sec_next = sec_reg + SW'(1);
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    v_next     = mac_y;
                    sec_next   = sec_reg + SW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= '0;
            step_reg      <= 3'd0;
            okflag_reg    <= 1'b0;
            enable_reg    <= 1'b0;
            sect_en_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sec_reg    <= sec_next;
            step_reg   <= step_next;
            okflag_reg <= okflag_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ENABLE:     enable_reg  <= cfg_data[0];
                    REG_SECTION_EN: sect_en_reg <= cfg_data[MASK_W-1:0];
                    default:        enable_reg  <= enable_reg;
                endcase
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (in_xfer)
        begin
            bend_reg <= block_end;
        end
        if ((state_reg == ST_RUN) && ((step_reg == 3'd2) || (step_reg == 3'd4)))
        begin
            hold_reg <= dly_rd;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_sample_reg <= okflag_reg ? r_sat : '0;
            out_ok_reg     <= okflag_reg;
            out_bend_reg   <= bend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = out_sample_reg;
    assign ok            = out_ok_reg;
    assign block_end_out = out_bend_reg;

    // Storage and arithmetic
    wbc_coef_mem #(
        .SECTIONS (SECTIONS)
    ) u_coef_mem (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (coef_waddr),
        .wr_data (coef_value),
        .rd_addr (coef_raddr),
        .rd_data (coef_rd)
    );

    wbc_delay_mem #(
        .SECTIONS (SECTIONS)
    ) u_delay_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (dly_clear),
        .wr_en   (dly_we),
        .wr_addr (dly_waddr),
        .wr_data (dly_wdata),
        .rd_addr (dly_raddr),
        .rd_data (dly_rd)
    );

    wbc_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .coef (coef_rd),
        .opnd (mac_opnd),
        .y    (mac_y)
    );

endmodule
